// ===== hw/rtl/percent_query_utf8_checker_defines.svh =====
// Assertion macros shared by the checker's queue and back-end modules.
`ifndef PERCENT_QUERY_UTF8_CHECKER_DEFINES_SVH
`define PERCENT_QUERY_UTF8_CHECKER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define PCQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PCQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pcq_pkg.sv =====
package pcq_pkg;

   localparam int MAX_LENGTH_WIDTH = 14;
   localparam logic [MAX_LENGTH_WIDTH-1:0] MAX_LENGTH_RESET = 14'd8192;

   // Encoded characters with a meaning of their own.
   localparam logic [7:0] CHAR_PLUS    = 8'h2b;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DEL     = 8'h7f;
   localparam logic [7:0] CHAR_HYPHEN  = 8'h2d;
   localparam logic [7:0] CHAR_DOT     = 8'h2e;
   localparam logic [7:0] CHAR_UNDER   = 8'h5f;
   localparam logic [7:0] CHAR_TILDE   = 8'h7e;

   // Code point limits.
   localparam int CP_WIDTH = 21;
   localparam logic [CP_WIDTH-1:0] CP_MIN_TWO   = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_MIN_THREE = 21'h000800;
   localparam logic [CP_WIDTH-1:0] CP_MIN_FOUR  = 21'h010000;
   localparam logic [CP_WIDTH-1:0] CP_MAX       = 21'h10ffff;
   localparam logic [CP_WIDTH-1:0] CP_SURR_LO   = 21'h00d800;
   localparam logic [CP_WIDTH-1:0] CP_SURR_HI   = 21'h00dfff;
   localparam logic [CP_WIDTH-1:0] CP_C1_LO     = 21'h000080;
   localparam logic [CP_WIDTH-1:0] CP_C1_HI     = 21'h00009f;

   // Sequence length classes.
   localparam logic [1:0] CLASS_NONE  = 2'd0;
   localparam logic [1:0] CLASS_TWO   = 2'd1;
   localparam logic [1:0] CLASS_THREE = 2'd2;
   localparam logic [1:0] CLASS_FOUR  = 2'd3;

   // Queue between front and back.
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = 1;
   localparam int QUEUE_COUNT_W = 2;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_phase_type;

   // One entry handed from the front to the back.
   typedef struct packed {
      logic       byte_valid;
      logic [7:0] data;
      logic       last;
      logic       front_ok;
   } entry_type;

endpackage

// ===== hw/rtl/pcq_front.sv =====
module pcq_front #(
   parameter int COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [pcq_pkg::MAX_LENGTH_WIDTH-1:0] csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_has_byte,
   input  logic                                 req_last,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output pcq_pkg::entry_type                   push_entry
);

   localparam int CMP_W = (COUNT_WIDTH > pcq_pkg::MAX_LENGTH_WIDTH) ?
                          COUNT_WIDTH : pcq_pkg::MAX_LENGTH_WIDTH;

   function automatic logic is_unreserved(input logic [7:0] c);
      return c inside {["A":"Z"], ["a":"z"], ["0":"9"], pcq_pkg::CHAR_HYPHEN,
                       pcq_pkg::CHAR_DOT, pcq_pkg::CHAR_UNDER, pcq_pkg::CHAR_TILDE};
   endfunction

   // Upper-case hex digit: top bit flags a valid digit, low four bits its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {["0":"9"]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {["A":"F"]}) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

   logic [pcq_pkg::MAX_LENGTH_WIDTH-1:0] max_length_ff;
   logic [COUNT_WIDTH-1:0]               count_ff, count_in, count_step;
   pcq_pkg::esc_phase_type               esc_ff, esc_in, esc_next;
   logic [3:0]                           nibble_ff, nibble_in;
   logic                                 failed_ff, failed_in, fail_next;

   logic       accept, len_bad, live, emit, char_bad, bad_decoded;
   logic [4:0] hex;
   logic [7:0] decoded, emit_byte;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      count_step  = (&count_ff) ? count_ff : count_ff + 1'b1;
      len_bad     = CMP_W'(count_step) > CMP_W'(max_length_ff);
      hex         = hex_digit(req_data_byte);
      decoded     = {nibble_ff, hex[3:0]};
      bad_decoded = is_unreserved(decoded) || (decoded <= pcq_pkg::CHAR_SPACE) ||
                    (decoded == pcq_pkg::CHAR_DEL);
      live        = req_has_byte && !failed_ff && !len_bad;
   end

   // Escape phase: next state.
   always_comb begin
      esc_next = esc_ff;
      if (live) begin
         case (esc_ff)
            pcq_pkg::ESC_NONE: begin
               if (req_data_byte == pcq_pkg::CHAR_PERCENT) begin
                  esc_next = pcq_pkg::ESC_HIGH;
               end
            end
            pcq_pkg::ESC_HIGH: begin
               if (hex[4]) begin
                  esc_next = pcq_pkg::ESC_LOW;
               end
            end
            pcq_pkg::ESC_LOW: begin
               if (hex[4]) begin
                  esc_next = pcq_pkg::ESC_NONE;
               end
            end
            default: begin
               esc_next = pcq_pkg::ESC_NONE;
            end
         endcase
      end
   end

   // Escape phase: decoded byte and rejection.
   always_comb begin
      emit      = 1'b0;
      emit_byte = req_data_byte;
      char_bad  = 1'b0;
      case (esc_ff)
         pcq_pkg::ESC_NONE: begin
            if (is_unreserved(req_data_byte)) begin
               emit = 1'b1;
            end else if (req_data_byte == pcq_pkg::CHAR_PLUS) begin
               emit      = 1'b1;
               emit_byte = pcq_pkg::CHAR_SPACE;
            end else if (req_data_byte != pcq_pkg::CHAR_PERCENT) begin
               char_bad = 1'b1;
            end
         end
         pcq_pkg::ESC_HIGH: begin
            char_bad = !hex[4];
         end
         pcq_pkg::ESC_LOW: begin
            if (!hex[4] || bad_decoded) begin
               char_bad = 1'b1;
            end else begin
               emit      = 1'b1;
               emit_byte = decoded;
            end
         end
         default: begin
            char_bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      fail_next  = failed_ff || (req_has_byte && len_bad) || (live && char_bad);
      push_valid = req_valid && ((live && emit && !char_bad) || req_last);
      push_entry.byte_valid = live && emit && !char_bad;
      push_entry.data       = emit_byte;
      push_entry.last       = req_last;
      push_entry.front_ok   = !fail_next && (esc_next == pcq_pkg::ESC_NONE);

      count_in  = count_ff;
      esc_in    = esc_ff;
      nibble_in = nibble_ff;
      failed_in = failed_ff;
      if (accept) begin
         if (req_last) begin
            count_in  = '0;
            esc_in    = pcq_pkg::ESC_NONE;
            failed_in = 1'b0;
         end else begin
            if (req_has_byte) begin
               count_in = count_step;
            end
            esc_in    = esc_next;
            failed_in = fail_next;
            if (live && (esc_ff == pcq_pkg::ESC_HIGH)) begin
               nibble_in = hex[3:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= pcq_pkg::MAX_LENGTH_RESET;
         count_ff      <= '0;
         esc_ff        <= pcq_pkg::ESC_NONE;
         failed_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
         count_ff  <= count_in;
         esc_ff    <= esc_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      nibble_ff <= nibble_in;
   end

endmodule

// ===== hw/rtl/pcq_queue.sv =====
`include "percent_query_utf8_checker_defines.svh"

module pcq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  pcq_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output pcq_pkg::entry_type pop_entry
);

   pcq_pkg::entry_type slot_ff [pcq_pkg::QUEUE_DEPTH];

   logic [pcq_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [pcq_pkg::QUEUE_COUNT_W-1:0] count_ff, count_in;
   logic                              push_take, pop_take;

   assign push_ready = count_ff != pcq_pkg::QUEUE_COUNT_W'(pcq_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_take  = push_valid && push_ready;
   assign pop_take   = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (push_take && !pop_take) begin
         count_in = count_ff + 1'b1;
      end else if (pop_take && !push_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_take) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_take) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `PCQ_ASSERT_NEXT(a_count_up, clock, reset, push_take && !pop_take, count_ff == $past(count_ff) + 2'd1, "queue fill count missed a push")
   `PCQ_ASSERT_NEXT(a_count_down, clock, reset, pop_take && !push_take, count_ff == $past(count_ff) - 2'd1, "queue fill count missed a pop")

endmodule

// ===== hw/rtl/pcq_back.sv =====
`include "percent_query_utf8_checker_defines.svh"

module pcq_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  pcq_pkg::entry_type pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_accepted
);

   logic [1:0]                     cont_ff, cont_in, cont_n;
   logic [pcq_pkg::CP_WIDTH-1:0]   acc_ff, acc_in, acc_n, minimum;
   logic [1:0]                     class_ff, class_in, class_n;
   logic                           failed_ff, failed_in, failed_n;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           accepted_ff, accepted_in;
   logic                           out_free, take, feed, bad, result;
   logic [7:0]                     b;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop_ready = !pop_entry.last || out_free;
   assign take      = pop_valid && pop_ready;
   assign b         = pop_entry.data;
   assign feed      = pop_entry.byte_valid && !failed_ff;

   // UTF-8 decoder step for one decoded byte.
   always_comb begin
      cont_n  = cont_ff;
      acc_n   = acc_ff;
      class_n = class_ff;
      bad     = 1'b0;
      case (class_ff)
         pcq_pkg::CLASS_TWO:   minimum = pcq_pkg::CP_MIN_TWO;
         pcq_pkg::CLASS_THREE: minimum = pcq_pkg::CP_MIN_THREE;
         default:              minimum = pcq_pkg::CP_MIN_FOUR;
      endcase
      if (feed) begin
         if (cont_ff != 2'd0) begin
            if (b[7:6] != 2'b10) begin
               bad = 1'b1;
            end else begin
               acc_n  = {acc_ff[pcq_pkg::CP_WIDTH-7:0], b[5:0]};
               cont_n = cont_ff - 2'd1;
               if ((cont_n == 2'd0) &&
                   ((acc_n < minimum) || (acc_n > pcq_pkg::CP_MAX) ||
                    ((acc_n >= pcq_pkg::CP_SURR_LO) && (acc_n <= pcq_pkg::CP_SURR_HI)) ||
                    ((acc_n >= pcq_pkg::CP_C1_LO) && (acc_n <= pcq_pkg::CP_C1_HI)))) begin
                  bad = 1'b1;
               end
            end
         end else if (b[7]) begin
            if (b[7:5] == 3'b110) begin
               cont_n  = 2'd1;
               acc_n   = pcq_pkg::CP_WIDTH'(b[4:0]);
               class_n = pcq_pkg::CLASS_TWO;
            end else if (b[7:4] == 4'b1110) begin
               cont_n  = 2'd2;
               acc_n   = pcq_pkg::CP_WIDTH'(b[3:0]);
               class_n = pcq_pkg::CLASS_THREE;
            end else if (b[7:3] == 5'b11110) begin
               cont_n  = 2'd3;
               acc_n   = pcq_pkg::CP_WIDTH'(b[2:0]);
               class_n = pcq_pkg::CLASS_FOUR;
            end else begin
               bad = 1'b1;
            end
         end
      end
      failed_n = failed_ff || bad;
      result   = pop_entry.front_ok && !failed_n && (cont_n == 2'd0);
   end

   always_comb begin
      cont_in      = cont_ff;
      acc_in       = acc_ff;
      class_in     = class_ff;
      failed_in    = failed_ff;
      accepted_in  = accepted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         if (pop_entry.last) begin
            cont_in      = 2'd0;
            class_in     = pcq_pkg::CLASS_NONE;
            failed_in    = 1'b0;
            rsp_valid_in = 1'b1;
            accepted_in  = result;
         end else begin
            cont_in   = cont_n;
            acc_in    = acc_n;
            class_in  = class_n;
            failed_in = failed_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_ff      <= 2'd0;
         class_ff     <= pcq_pkg::CLASS_NONE;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cont_ff      <= cont_in;
         class_ff     <= class_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      accepted_ff <= accepted_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = accepted_ff;

   `PCQ_ASSERT_IMPL(a_pending_has_class, clock, reset, cont_ff != 2'd0, class_ff != pcq_pkg::CLASS_NONE, "continuations pending without a sequence class")
   `PCQ_ASSERT_NEXT(a_clear_after_end, clock, reset, take && pop_entry.last, (cont_ff == 2'd0) && !failed_ff && rsp_valid_ff, "decoder state not cleared after end mark")

endmodule

// ===== hw/rtl/percent_query_utf8_checker.sv =====
// Percent-encoded query value checker. Requests carry one encoded byte of a
// URL query value each, with an end mark on the final request; the block
// answers each value with a single accepted flag. Unreserved characters pass,
// a plus sign stands for a space, and a percent escape needs two upper-case
// hex digits naming a byte that could not have been sent plainly. The decoded
// bytes must be well-formed UTF-8 without overlong forms, surrogates, code
// points above U+10FFFF or C1 controls, and a value longer than max_length
// encoded bytes is rejected. A request without a byte that carries the end
// mark closes the value as it stands, so on its own it gives an accepted empty
// value. The front end takes one request every clock cycle while the queue has
// room, counting bytes and resolving escapes; it hands decoded bytes through a
// two-entry queue to the UTF-8 decoder, which retires one entry per cycle, an
// end mark only with the response register free. Throughput is one request per
// cycle while responses are taken. The decoder registers the result on the
// response port when it takes the end mark. A response left waiting stalls the
// decoder only at the next end mark; the queue then fills and holds off further
// requests. max_length resets to 8192 and is written through csr_write_enable
// and csr_write_data; the user must write it only while the block is idle, as
// the block does not enforce it. COUNT_WIDTH sizes the saturating byte counter.
module percent_query_utf8_checker #(
   parameter int COUNT_WIDTH = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_has_byte,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_accepted,
   input  logic                                 csr_write_enable,
   input  logic [pcq_pkg::MAX_LENGTH_WIDTH-1:0] csr_write_data
);

   // Front end to queue.
   logic               push_valid, push_ready;
   pcq_pkg::entry_type push_entry;

   // Queue to decoder.
   logic               pop_valid, pop_ready;
   pcq_pkg::entry_type pop_entry;

   // Byte counting, length limit, character classes and escape decoding.
   pcq_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last         (req_last),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   // Short queue so that the two halves stall independently.
   pcq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // UTF-8 validation and the registered response.
   pcq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted)
   );

endmodule
